// ===== rtl/quaternion_vector_rotation_defines.svh =====
// Assertion macros used by the quaternion vector rotation control (qvr_ctrl).
`ifndef QUATERNION_VECTOR_ROTATION_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QVR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define QVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/qvr_pkg.sv =====
// Types and constants of the quaternion vector rotation pipeline.
package qvr_pkg;

	// Field widths
	localparam int QVR_IN_W   = 16;
	localparam int QVR_OUT_W  = 18;
	localparam int QVR_FRAC   = 30;

	// Datapath widths: conjugated component, first and second product terms and sums
	localparam int QVR_P_W    = QVR_IN_W + 1;
	localparam int QVR_M1_W   = QVR_P_W + QVR_IN_W;
	localparam int QVR_T1_W   = QVR_M1_W + 2;
	localparam int QVR_M2_W   = QVR_T1_W + QVR_P_W;
	localparam int QVR_SUM_W  = QVR_M2_W + 2;
	localparam int QVR_RND_W  = QVR_SUM_W - QVR_FRAC;

	localparam int QVR_STAGES = 6;

	typedef logic signed [QVR_IN_W-1:0]  qvr_in_t;
	typedef logic signed [QVR_OUT_W-1:0] qvr_out_t;
	typedef logic signed [QVR_P_W-1:0]   qvr_p_t;
	typedef logic signed [QVR_M1_W-1:0]  qvr_m1_t;
	typedef logic signed [QVR_T1_W-1:0]  qvr_t1_t;
	typedef logic signed [QVR_M2_W-1:0]  qvr_m2_t;
	typedef logic signed [QVR_SUM_W-1:0] qvr_sum_t;
	typedef logic signed [QVR_RND_W-1:0] qvr_rnd_t;

	// Half an LSB of the result, added before the arithmetic shift
	localparam qvr_sum_t QVR_HALF    = qvr_sum_t'(1) <<< (QVR_FRAC - 1);
	localparam qvr_out_t QVR_OUT_MAX = {1'b0, {(QVR_OUT_W-1){1'b1}}};
	localparam qvr_out_t QVR_OUT_MIN = {1'b1, {(QVR_OUT_W-1){1'b0}}};

	// Per-stage load enables from the pipeline control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} qvr_stage_en_t;

endpackage

// ===== rtl/qvr_if.sv =====
// Valid/ready channel interfaces for rotation requests and rotated vectors.
interface qvr_item_if;
	import qvr_pkg::*;

	logic    valid;
	logic    ready;
	qvr_in_t quat_x;
	qvr_in_t quat_y;
	qvr_in_t quat_z;
	qvr_in_t quat_w;
	qvr_in_t vec_x;
	qvr_in_t vec_y;
	qvr_in_t vec_z;
	logic    inverse_dir;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
		inverse_dir, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
		inverse_dir, output ready);
endinterface

interface qvr_result_if;
	import qvr_pkg::*;

	logic     valid;
	logic     ready;
	qvr_out_t out_x;
	qvr_out_t out_y;
	qvr_out_t out_z;
	logic     saturated;

	modport source (output valid, out_x, out_y, out_z, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

// ===== rtl/quaternion_vector_rotation.sv =====
// Top level of the quaternion vector rotation pipeline.
//
// Rotates a 16-bit integer 3-vector by a Q1.15 quaternion (x, y, z, w), giving
// conj(q) v q when inverse_dir is 0 and q v conj(q) when it is 1, kept at full
// precision, rounded half up by 2^30 and saturated to 18 signed bits with a
// flag. The quaternion is used as given, so a non-unit q also scales the
// vector by |q|^2. Throughput is one item per clock while the output is not
// stalled. An item passes six register stages: conjugate select, first partial
// products, first sums, second partial products, second sums, round and saturate.
// The edge that transfers the item loads the first stage, and each later stage
// loads in turn until the sixth offers the result. Every stage has its own load
// enable, so a stalled result holds only the stages behind it that are full
// and empty stages keep taking items.
module quaternion_vector_rotation (
	input logic         clk,
	input logic         arst_n,
	qvr_item_if.sink     item,
	qvr_result_if.source result
);
	import qvr_pkg::*;

	qvr_stage_en_t stage_en;
	qvr_p_t        px_s3, py_s3, pz_s3, pw_s3;
	qvr_t1_t       tx_s3, ty_s3, tz_s3, tw_s3;
	qvr_sum_t      rx_s5, ry_s5, rz_s5;
	qvr_out_t      out_x_s6, out_y_s6, out_z_s6;
	logic          sat_s6;

	// Valid bits and stage enables
	qvr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stage_en  (stage_en)
	);

	// p * v
	qvr_vec_mul u_vec_mul (
		.clk         (clk),
		.stage_en    (stage_en),
		.quat_x      (item.quat_x),
		.quat_y      (item.quat_y),
		.quat_z      (item.quat_z),
		.quat_w      (item.quat_w),
		.vec_x       (item.vec_x),
		.vec_y       (item.vec_y),
		.vec_z       (item.vec_z),
		.inverse_dir (item.inverse_dir),
		.px_s3       (px_s3),
		.py_s3       (py_s3),
		.pz_s3       (pz_s3),
		.pw_s3       (pw_s3),
		.tx_s3       (tx_s3),
		.ty_s3       (ty_s3),
		.tz_s3       (tz_s3),
		.tw_s3       (tw_s3)
	);

	// (p * v) * conj(p)
	qvr_conj_mul u_conj_mul (
		.clk      (clk),
		.stage_en (stage_en),
		.px       (px_s3),
		.py       (py_s3),
		.pz       (pz_s3),
		.pw       (pw_s3),
		.tx       (tx_s3),
		.ty       (ty_s3),
		.tz       (tz_s3),
		.tw       (tw_s3),
		.rx_s5    (rx_s5),
		.ry_s5    (ry_s5),
		.rz_s5    (rz_s5)
	);

	// Rounding, saturation and output register
	qvr_round_sat u_round_sat (
		.clk      (clk),
		.stage_en (stage_en),
		.rx       (rx_s5),
		.ry       (ry_s5),
		.rz       (rz_s5),
		.out_x_s6 (out_x_s6),
		.out_y_s6 (out_y_s6),
		.out_z_s6 (out_z_s6),
		.sat_s6   (sat_s6)
	);

	assign result.out_x     = out_x_s6;
	assign result.out_y     = out_y_s6;
	assign result.out_z     = out_z_s6;
	assign result.saturated = sat_s6;
endmodule

// ===== rtl/qvr_ctrl.sv =====
// Valid tracking and per-stage enables of the rotation pipeline.
`include "quaternion_vector_rotation_defines.svh"

module qvr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output qvr_pkg::qvr_stage_en_t stage_en
);
	import qvr_pkg::*;

	logic [QVR_STAGES-1:0] valid_q;
	logic [QVR_STAGES-1:0] en;

	// A stage loads when it is empty or its content moves on
	always_comb begin
		en[QVR_STAGES-1] = !valid_q[QVR_STAGES-1] || out_ready;
		for (int k = QVR_STAGES - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	// Valid bits move with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < QVR_STAGES; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_ready    = en[0];
	assign out_valid   = valid_q[QVR_STAGES-1];
	assign stage_en.s1 = en[0];
	assign stage_en.s2 = en[1];
	assign stage_en.s3 = en[2];
	assign stage_en.s4 = en[3];
	assign stage_en.s5 = en[4];
	assign stage_en.s6 = en[5];

	// A held stage keeps its item
	`QVR_ASSERT_NEXT(a_held_stage_keeps, clk, arst_n, |(valid_q & ~en), ((valid_q & $past(valid_q & ~en)) == $past(valid_q & ~en)), "stalled stage lost its item")
	// Full pipeline with a stalled output takes nothing
	`QVR_ASSERT_NOW(a_full_stall_blocks, clk, arst_n, (&valid_q) && !out_ready, !in_ready, "input taken while pipeline full and stalled")
	// No result appears from an empty pipeline
	`QVR_ASSERT_NEXT(a_no_phantom, clk, arst_n, (valid_q == '0) && !(in_valid && in_ready), !valid_q[QVR_STAGES-1], "result appeared with nothing in flight")
endmodule

// ===== rtl/qvr_vec_mul.sv =====
// First Hamilton product p * v with p = q or conj(q), stages 1 to 3.
module qvr_vec_mul (
	input  logic                   clk,
	input  qvr_pkg::qvr_stage_en_t stage_en,
	input  qvr_pkg::qvr_in_t       quat_x,
	input  qvr_pkg::qvr_in_t       quat_y,
	input  qvr_pkg::qvr_in_t       quat_z,
	input  qvr_pkg::qvr_in_t       quat_w,
	input  qvr_pkg::qvr_in_t       vec_x,
	input  qvr_pkg::qvr_in_t       vec_y,
	input  qvr_pkg::qvr_in_t       vec_z,
	input  logic                   inverse_dir,
	output qvr_pkg::qvr_p_t        px_s3,
	output qvr_pkg::qvr_p_t        py_s3,
	output qvr_pkg::qvr_p_t        pz_s3,
	output qvr_pkg::qvr_p_t        pw_s3,
	output qvr_pkg::qvr_t1_t       tx_s3,
	output qvr_pkg::qvr_t1_t       ty_s3,
	output qvr_pkg::qvr_t1_t       tz_s3,
	output qvr_pkg::qvr_t1_t       tw_s3
);
	import qvr_pkg::*;

	qvr_p_t  px_s1, py_s1, pz_s1, pw_s1;
	qvr_in_t vx_s1, vy_s1, vz_s1;
	qvr_p_t  px_s2, py_s2, pz_s2, pw_s2;
	qvr_m1_t m_s2 [12];

	// Stage 1: conjugate for the frame conversion when inverse_dir is 0, else q as given; 17 bits keep -(-1.0) exact
	always_ff @(posedge clk) begin
		if (stage_en.s1) begin
			px_s1 <= inverse_dir ? qvr_p_t'(quat_x) : -qvr_p_t'(quat_x);
			py_s1 <= inverse_dir ? qvr_p_t'(quat_y) : -qvr_p_t'(quat_y);
			pz_s1 <= inverse_dir ? qvr_p_t'(quat_z) : -qvr_p_t'(quat_z);
			pw_s1 <= qvr_p_t'(quat_w);
			vx_s1 <= vec_x;
			vy_s1 <= vec_y;
			vz_s1 <= vec_z;
		end
	end

	// Stage 2: the twelve partial products (vector scalar part is zero)
	always_ff @(posedge clk) begin
		if (stage_en.s2) begin
			m_s2[0]  <= qvr_m1_t'(pw_s1) * qvr_m1_t'(vx_s1);
			m_s2[1]  <= qvr_m1_t'(pz_s1) * qvr_m1_t'(vy_s1);
			m_s2[2]  <= qvr_m1_t'(py_s1) * qvr_m1_t'(vz_s1);
			m_s2[3]  <= qvr_m1_t'(pz_s1) * qvr_m1_t'(vx_s1);
			m_s2[4]  <= qvr_m1_t'(pw_s1) * qvr_m1_t'(vy_s1);
			m_s2[5]  <= qvr_m1_t'(px_s1) * qvr_m1_t'(vz_s1);
			m_s2[6]  <= qvr_m1_t'(py_s1) * qvr_m1_t'(vx_s1);
			m_s2[7]  <= qvr_m1_t'(px_s1) * qvr_m1_t'(vy_s1);
			m_s2[8]  <= qvr_m1_t'(pw_s1) * qvr_m1_t'(vz_s1);
			m_s2[9]  <= qvr_m1_t'(px_s1) * qvr_m1_t'(vx_s1);
			m_s2[10] <= qvr_m1_t'(py_s1) * qvr_m1_t'(vy_s1);
			m_s2[11] <= qvr_m1_t'(pz_s1) * qvr_m1_t'(vz_s1);
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			pz_s2    <= pz_s1;
			pw_s2    <= pw_s1;
		end
	end

	// Stage 3: signed sums of the Hamilton product
	always_ff @(posedge clk) begin
		if (stage_en.s3) begin
			tx_s3 <= qvr_t1_t'(m_s2[0]) - qvr_t1_t'(m_s2[1]) + qvr_t1_t'(m_s2[2]);
			ty_s3 <= qvr_t1_t'(m_s2[3]) + qvr_t1_t'(m_s2[4]) - qvr_t1_t'(m_s2[5]);
			tz_s3 <= qvr_t1_t'(m_s2[7]) + qvr_t1_t'(m_s2[8]) - qvr_t1_t'(m_s2[6]);
			tw_s3 <= -qvr_t1_t'(m_s2[9]) - qvr_t1_t'(m_s2[10]) - qvr_t1_t'(m_s2[11]);
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			pz_s3 <= pz_s2;
			pw_s3 <= pw_s2;
		end
	end
endmodule

// ===== rtl/qvr_conj_mul.sv =====
// Second Hamilton product t * conj(p), vector part only, stages 4 and 5.
module qvr_conj_mul (
	input  logic                   clk,
	input  qvr_pkg::qvr_stage_en_t stage_en,
	input  qvr_pkg::qvr_p_t        px,
	input  qvr_pkg::qvr_p_t        py,
	input  qvr_pkg::qvr_p_t        pz,
	input  qvr_pkg::qvr_p_t        pw,
	input  qvr_pkg::qvr_t1_t       tx,
	input  qvr_pkg::qvr_t1_t       ty,
	input  qvr_pkg::qvr_t1_t       tz,
	input  qvr_pkg::qvr_t1_t       tw,
	output qvr_pkg::qvr_sum_t      rx_s5,
	output qvr_pkg::qvr_sum_t      ry_s5,
	output qvr_pkg::qvr_sum_t      rz_s5
);
	import qvr_pkg::*;

	qvr_m2_t m_s4 [12];

	// Stage 4: partial products; the conjugate's signs are folded into the sums
	always_ff @(posedge clk) begin
		if (stage_en.s4) begin
			m_s4[0]  <= qvr_m2_t'(tw) * qvr_m2_t'(px);
			m_s4[1]  <= qvr_m2_t'(tz) * qvr_m2_t'(py);
			m_s4[2]  <= qvr_m2_t'(ty) * qvr_m2_t'(pz);
			m_s4[3]  <= qvr_m2_t'(tx) * qvr_m2_t'(pw);
			m_s4[4]  <= qvr_m2_t'(tz) * qvr_m2_t'(px);
			m_s4[5]  <= qvr_m2_t'(tw) * qvr_m2_t'(py);
			m_s4[6]  <= qvr_m2_t'(tx) * qvr_m2_t'(pz);
			m_s4[7]  <= qvr_m2_t'(ty) * qvr_m2_t'(pw);
			m_s4[8]  <= qvr_m2_t'(ty) * qvr_m2_t'(px);
			m_s4[9]  <= qvr_m2_t'(tx) * qvr_m2_t'(py);
			m_s4[10] <= qvr_m2_t'(tw) * qvr_m2_t'(pz);
			m_s4[11] <= qvr_m2_t'(tz) * qvr_m2_t'(pw);
		end
	end

	// Stage 5: four-term sums, full precision
	always_ff @(posedge clk) begin
		if (stage_en.s5) begin
			rx_s5 <= qvr_sum_t'(m_s4[1]) + qvr_sum_t'(m_s4[3])
				- qvr_sum_t'(m_s4[0]) - qvr_sum_t'(m_s4[2]);
			ry_s5 <= qvr_sum_t'(m_s4[6]) + qvr_sum_t'(m_s4[7])
				- qvr_sum_t'(m_s4[4]) - qvr_sum_t'(m_s4[5]);
			rz_s5 <= qvr_sum_t'(m_s4[8]) + qvr_sum_t'(m_s4[11])
				- qvr_sum_t'(m_s4[9]) - qvr_sum_t'(m_s4[10]);
		end
	end
endmodule

// ===== rtl/qvr_round_sat.sv =====
// Round half up, shift out the fraction and saturate to 18 bits, stage 6.
module qvr_round_sat (
	input  logic                   clk,
	input  qvr_pkg::qvr_stage_en_t stage_en,
	input  qvr_pkg::qvr_sum_t      rx,
	input  qvr_pkg::qvr_sum_t      ry,
	input  qvr_pkg::qvr_sum_t      rz,
	output qvr_pkg::qvr_out_t      out_x_s6,
	output qvr_pkg::qvr_out_t      out_y_s6,
	output qvr_pkg::qvr_out_t      out_z_s6,
	output logic                   sat_s6
);
	import qvr_pkg::*;

	qvr_rnd_t rnd_x, rnd_y, rnd_z;
	logic     ovf_x, ovf_y, ovf_z;

	// floor((s + half) / 2^30): take the upper bits after adding half
	function automatic qvr_rnd_t round_shift(input qvr_sum_t s);
		qvr_sum_t t;
		t = s + QVR_HALF;
		return t[QVR_SUM_W-1:QVR_FRAC];
	endfunction

	// Out of range when the bits above the result are not all sign
	function automatic logic out_of_range(input qvr_rnd_t r);
		return !((&r[QVR_RND_W-1:QVR_OUT_W-1]) || !(|r[QVR_RND_W-1:QVR_OUT_W-1]));
	endfunction

	function automatic qvr_out_t clamp(input qvr_rnd_t r, input logic ovf);
		qvr_out_t c;
		if (!ovf) begin
			c = r[QVR_OUT_W-1:0];
		end else if (r[QVR_RND_W-1]) begin
			c = QVR_OUT_MIN;
		end else begin
			c = QVR_OUT_MAX;
		end
		return c;
	endfunction

	always_comb begin
		rnd_x = round_shift(rx);
		rnd_y = round_shift(ry);
		rnd_z = round_shift(rz);
		ovf_x = out_of_range(rnd_x);
		ovf_y = out_of_range(rnd_y);
		ovf_z = out_of_range(rnd_z);
	end

	// Output register
	always_ff @(posedge clk) begin
		if (stage_en.s6) begin
			out_x_s6 <= clamp(rnd_x, ovf_x);
			out_y_s6 <= clamp(rnd_y, ovf_y);
			out_z_s6 <= clamp(rnd_z, ovf_z);
			sat_s6   <= ovf_x || ovf_y || ovf_z;
		end
	end
endmodule
